// ----- hw/rtl/plsps_pkg.sv -----
// Shared types and constants for the printer link serial slave.
package plsps_pkg;

  localparam logic [15:0] TimeoutReset = 16'd500;
  localparam logic [7:0]  BusyReset    = 8'd20;
  localparam logic [7:0]  DevIdReset   = 8'h81;
  localparam logic [15:0] SyncWord     = 16'h8833;
  localparam int          QueueDepth   = 2;

  localparam logic [7:0] CmdInit    = 8'h01;
  localparam logic [7:0] CmdPrint   = 8'h02;
  localparam logic [7:0] CmdData    = 8'h04;
  localparam logic [7:0] CmdBreak   = 8'h08;
  localparam logic [7:0] CmdInquiry = 8'h0F;

  localparam logic [15:0] StBusy   = 16'h0002;
  localparam logic [15:0] StFull   = 16'h0004;
  localparam logic [15:0] StUnproc = 16'h0008;

  localparam logic [1:0] CfgTimeout = 2'd0;
  localparam logic [1:0] CfgBusy    = 2'd1;
  localparam logic [1:0] CfgDevId   = 2'd2;

  typedef enum logic [1:0] {
    MODE_RESET = 2'd0,
    MODE_8     = 2'd1,
    MODE_16BE  = 2'd2,
    MODE_16LE  = 2'd3
  } word_mode_t;

  typedef enum logic [2:0] {
    STG_CMD   = 3'd0,
    STG_LEN   = 3'd1,
    STG_PAY   = 3'd2,
    STG_CSUM  = 3'd3,
    STG_DUMMY = 3'd4
  } stage_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_INIT    = 3'd1,
    EV_PRINT   = 3'd2,
    EV_DATA    = 3'd3,
    EV_DATAEND = 3'd4,
    EV_BREAK   = 3'd5,
    EV_INQUIRY = 3'd6
  } event_t;

  typedef struct packed {
    logic        kind;
    logic        sclk_level;
    logic        sout_bit;
    logic [15:0] tick_ms;
  } in_item_t;

  typedef struct packed {
    logic       sin_out;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [2:0] packet_event;
    logic       timed_out;
    logic       last;
  } out_item_t;

  // One processed request: up to four bytes plus the shared fields.
  typedef struct packed {
    logic [2:0]  n_bytes;
    logic [31:0] bytes;
    logic        sin_out;
    logic [2:0]  packet_event;
    logic        timed_out;
  } burst_t;

endpackage

// ----- hw/rtl/plsps_front.sv -----
// Front part: runs the link state machine once per request and queues the burst.
module plsps_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  plsps_pkg::in_item_t in_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                q_valid,
  input  logic                q_pop,
  output plsps_pkg::burst_t   q_data
);
  localparam int D = plsps_pkg::QueueDepth;
  localparam int AW = (D > 1) ? $clog2(D) : 1;

  logic [15:0] tlim_r, tleft_r, pre_r, mask_r, rx_r, tx_r, plen_r, pidx_r, stat_r;
  logic [7:0]  busyq_r, cmd_r, comp_r, busyc_r;
  logic [1:0]  untr_r;
  logic [2:0]  datac_r;
  logic        synced_r, sin_r;
  plsps_pkg::word_mode_t mode_r;
  plsps_pkg::stage_t     stg_r;

  logic [15:0] tlim_nxt, tleft_nxt, pre_nxt, mask_nxt, rx_nxt, tx_nxt, plen_nxt;
  logic [15:0] pidx_nxt, stat_nxt;
  logic [7:0]  busyq_nxt, cmd_nxt, comp_nxt, busyc_nxt;
  logic [1:0]  untr_nxt;
  logic [2:0]  datac_nxt;
  logic        synced_nxt, sin_nxt;
  plsps_pkg::word_mode_t mode_nxt;
  plsps_pkg::stage_t     stg_nxt;
  plsps_pkg::burst_t     b;

  plsps_pkg::burst_t q_mem [D];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          acc;

  assign in_stall  = (cnt_r == (AW+1)'(D));
  assign cfg_ready = 1'b1;
  assign acc       = in_valid && !in_stall;
  assign q_valid   = (cnt_r != '0);
  assign q_data    = q_mem[rp_r];

  always_comb begin
    logic        done;
    logic [15:0] w, pl, sw;
    logic [15:0] st_tx;
    logic [2:0]  n;
    logic        do_start;
    plsps_pkg::word_mode_t smode;
    tlim_nxt = tlim_r; tleft_nxt = tleft_r; pre_nxt = pre_r; mask_nxt = mask_r;
    rx_nxt = rx_r; tx_nxt = tx_r; plen_nxt = plen_r; pidx_nxt = pidx_r;
    stat_nxt = stat_r; busyq_nxt = busyq_r; cmd_nxt = cmd_r; comp_nxt = comp_r;
    busyc_nxt = busyc_r; untr_nxt = untr_r; datac_nxt = datac_r;
    synced_nxt = synced_r; sin_nxt = sin_r; mode_nxt = mode_r; stg_nxt = stg_r;
    b = '0; done = 1'b0; w = '0; pl = '0; sw = '0; n = '0;
    do_start = 1'b0; smode = plsps_pkg::MODE_RESET; st_tx = '0;
    if (cfg_valid) begin
      case (cfg_index)
        plsps_pkg::CfgTimeout: tlim_nxt = cfg_data;
        plsps_pkg::CfgBusy:    busyq_nxt = cfg_data[7:0];
        plsps_pkg::CfgDevId:   stat_nxt = {cfg_data[7:0], stat_r[7:0]};
        default: ;
      endcase
    end
    if (acc) begin
      if (in_data.kind) begin
        if (tleft_r != '0) begin
          tleft_nxt = (tleft_r > in_data.tick_ms) ? tleft_r - in_data.tick_ms : '0;
          if (tleft_nxt == '0) begin
            synced_nxt = 1'b0; rx_nxt = '0; tx_nxt = '0; sin_nxt = 1'b0;
            mask_nxt = '0; stat_nxt = {stat_r[15:8], 8'h00};
            b.timed_out = 1'b1;
          end
        end
      end else if (!synced_r) begin
        if (in_data.sclk_level) begin
          if ((pre_r | {15'd0, in_data.sout_bit}) != plsps_pkg::SyncWord) begin
            pre_nxt = (pre_r | {15'd0, in_data.sout_bit}) << 1;
          end else begin
            stg_nxt = plsps_pkg::STG_CMD; pre_nxt = '0; synced_nxt = 1'b1;
            do_start = 1'b1; smode = plsps_pkg::MODE_16BE;
          end
        end
      end else begin
        done = 1'b1;
        if (mask_r != '0) begin
          if (in_data.sclk_level) begin
            if (in_data.sout_bit) rx_nxt = rx_r | mask_r;
            mask_nxt = mask_r >> 1;
            done = (mask_nxt == '0);
          end else begin
            sin_nxt = (mask_r & tx_r) != '0;
            done = 1'b0;
          end
        end
        if (done) begin
          w = rx_nxt;
          sw = stat_nxt;
          if (stg_r == plsps_pkg::STG_CMD) begin
            b.bytes[31:16] = plsps_pkg::SyncWord; n = 3'd2;
          end
          if (mode_r == plsps_pkg::MODE_8) begin
            b.bytes[31 - 8*n -: 8] = w[7:0]; n = n + 3'd1;
          end else if (mode_r != plsps_pkg::MODE_RESET) begin
            if (stg_r == plsps_pkg::STG_DUMMY) w = tx_r;
            b.bytes[31 - 8*n -: 8] = w[15:8];
            b.bytes[23 - 8*n -: 8] = w[7:0]; n = n + 3'd2;
          end
          b.n_bytes = n;
          tleft_nxt = tlim_r;
          do_start = 1'b1;
          case (stg_r)
            plsps_pkg::STG_CMD: begin
              cmd_nxt = rx_nxt[15:8]; comp_nxt = rx_nxt[7:0];
              stg_nxt = plsps_pkg::STG_LEN; smode = plsps_pkg::MODE_16LE;
            end
            plsps_pkg::STG_LEN: begin
              pl = (mode_r == plsps_pkg::MODE_16LE) ? {rx_nxt[7:0], rx_nxt[15:8]} : rx_nxt;
              pidx_nxt = '0;
              if (cmd_r == plsps_pkg::CmdData && pl != '0) begin
                stg_nxt = plsps_pkg::STG_PAY; smode = plsps_pkg::MODE_8;
              end else if (cmd_r == plsps_pkg::CmdPrint) begin
                stg_nxt = plsps_pkg::STG_PAY; smode = plsps_pkg::MODE_8;
                if (pl > 16'd4) pl = 16'd4;
              end else begin
                stg_nxt = plsps_pkg::STG_CSUM; smode = plsps_pkg::MODE_16LE;
              end
              plen_nxt = pl;
            end
            plsps_pkg::STG_PAY: begin
              pidx_nxt = pidx_r + 16'd1;
              if (pidx_nxt >= plen_r) begin
                stg_nxt = plsps_pkg::STG_CSUM; smode = plsps_pkg::MODE_16LE;
              end else begin
                smode = plsps_pkg::MODE_8;
              end
            end
            plsps_pkg::STG_CSUM: begin
              case (cmd_r)
                plsps_pkg::CmdInit: begin
                  datac_nxt = 3'd6; untr_nxt = '0; busyc_nxt = '0;
                  sw = sw & ~(plsps_pkg::StFull | plsps_pkg::StBusy);
                end
                plsps_pkg::CmdPrint: busyc_nxt = busyq_r;
                plsps_pkg::CmdData:  untr_nxt = 2'd3;
                plsps_pkg::CmdBreak: begin
                  sw = (sw & ~16'h00F9) | plsps_pkg::StFull | plsps_pkg::StBusy;
                end
                plsps_pkg::CmdInquiry: begin
                  if (untr_r != '0) begin
                    untr_nxt = untr_r - 2'd1;
                    if (untr_nxt == '0) begin
                      sw = sw & ~plsps_pkg::StUnproc;
                      if (busyc_r != '0) sw = sw | plsps_pkg::StBusy | plsps_pkg::StFull;
                    end
                  end else if (busyc_r != '0) begin
                    busyc_nxt = busyc_r - 8'd1;
                    if (busyc_nxt == '0) sw = sw & ~plsps_pkg::StBusy;
                  end
                end
                default: ;
              endcase
              stat_nxt = sw;
              stg_nxt = plsps_pkg::STG_DUMMY; smode = plsps_pkg::MODE_16BE;
              st_tx = sw;
            end
            plsps_pkg::STG_DUMMY: begin
              case (cmd_r)
                plsps_pkg::CmdInit:  b.packet_event = plsps_pkg::EV_INIT;
                plsps_pkg::CmdPrint: b.packet_event = plsps_pkg::EV_PRINT;
                plsps_pkg::CmdData: begin
                  if (datac_r != '0) datac_nxt = datac_r - 3'd1;
                  sw = sw & ~(plsps_pkg::StFull | plsps_pkg::StUnproc);
                  if (plen_r == '0) sw = sw | plsps_pkg::StFull;
                  b.packet_event = (plen_r != '0) ? plsps_pkg::EV_DATA
                                                  : plsps_pkg::EV_DATAEND;
                end
                plsps_pkg::CmdBreak: b.packet_event = plsps_pkg::EV_BREAK;
                plsps_pkg::CmdInquiry: begin
                  sw = sw & ~plsps_pkg::StUnproc;
                  if (untr_r == '0 && busyc_r == '0) sw = sw & ~plsps_pkg::StFull;
                  b.packet_event = plsps_pkg::EV_INQUIRY;
                end
                default: ;
              endcase
              stat_nxt = sw;
              stg_nxt = plsps_pkg::STG_CMD; smode = plsps_pkg::MODE_RESET;
            end
            default: begin
              stg_nxt = plsps_pkg::STG_CMD; smode = plsps_pkg::MODE_RESET;
            end
          endcase
        end
      end
      if (do_start) begin
        rx_nxt = '0; mode_nxt = smode;
        case (smode)
          plsps_pkg::MODE_RESET: begin
            mask_nxt = '0; sin_nxt = 1'b0; tx_nxt = 16'hFFFF; synced_nxt = 1'b0;
          end
          plsps_pkg::MODE_8:    begin mask_nxt = 16'h0080; tx_nxt = st_tx; end
          plsps_pkg::MODE_16BE: begin mask_nxt = 16'h8000; tx_nxt = st_tx; end
          default: begin mask_nxt = 16'h8000; tx_nxt = {st_tx[7:0], st_tx[15:8]}; end
        endcase
      end
      b.sin_out = sin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlim_r <= plsps_pkg::TimeoutReset; busyq_r <= plsps_pkg::BusyReset;
      stat_r <= {plsps_pkg::DevIdReset, 8'h00};
      tleft_r <= '0; pre_r <= '0; mask_r <= '0; rx_r <= '0; tx_r <= '0;
      plen_r <= '0; pidx_r <= '0; cmd_r <= '0; comp_r <= '0; busyc_r <= '0;
      untr_r <= '0; datac_r <= '0; synced_r <= 1'b0; sin_r <= 1'b0;
      mode_r <= plsps_pkg::MODE_RESET; stg_r <= plsps_pkg::STG_CMD;
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      tlim_r <= tlim_nxt; busyq_r <= busyq_nxt; stat_r <= stat_nxt;
      tleft_r <= tleft_nxt; pre_r <= pre_nxt; mask_r <= mask_nxt; rx_r <= rx_nxt;
      tx_r <= tx_nxt; plen_r <= plen_nxt; pidx_r <= pidx_nxt; cmd_r <= cmd_nxt;
      comp_r <= comp_nxt; busyc_r <= busyc_nxt; untr_r <= untr_nxt;
      datac_r <= datac_nxt; synced_r <= synced_nxt; sin_r <= sin_nxt;
      mode_r <= mode_nxt; stg_r <= stg_nxt;
      if (acc) wp_r <= (wp_r == AW'(D-1)) ? '0 : wp_r + 1'b1;
      if (q_pop) rp_r <= (rp_r == AW'(D-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(acc) - (AW+1)'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) q_mem[wp_r] <= b;
  end
endmodule

// ----- hw/rtl/plsps_back.sv -----
// Back part: unrolls each queued burst into result items.
module plsps_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  plsps_pkg::burst_t    q_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output plsps_pkg::out_item_t out_data
);
  logic [1:0] idx_r, idx_nxt;
  logic       fin;
  logic       nb;
  logic [2:0] cnt;

  assign nb  = (q_data.n_bytes != '0);
  assign cnt = nb ? q_data.n_bytes : 3'd1;
  assign fin = ({1'b0, idx_r} == cnt - 3'd1);
  assign out_valid = q_valid;
  assign q_pop = q_valid && !out_stall && fin;

  always_comb begin
    out_data = '0;
    out_data.sin_out    = q_data.sin_out;
    out_data.byte_valid = nb;
    out_data.byte_value = nb ? q_data.bytes[31 - 8*idx_r -: 8] : 8'h00;
    out_data.packet_event = fin ? q_data.packet_event : plsps_pkg::EV_NONE;
    out_data.timed_out  = q_data.timed_out;
    out_data.last       = fin;
    idx_nxt = idx_r;
    if (q_valid && !out_stall) idx_nxt = fin ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else idx_r <= idx_nxt;
  end
endmodule

// ----- hw/rtl/printer_link_serial_packet_slave.sv -----
// Top level of the printer link serial packet slave.
// A request's burst is registered into a two-entry queue, one request per cycle
// while in_stall is low; its first result is offered when it reaches the head.
// The back end gives one result per cycle unless out_stall, 1 to 4 per request.
// Reset: synchronous active-low rst_n restores registers and empties the queue.
module printer_link_serial_packet_slave (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  plsps_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output plsps_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  logic q_valid, q_pop;
  plsps_pkg::burst_t q_data;

  plsps_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .q_valid, .q_pop, .q_data
  );

  plsps_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data, .out_valid, .out_stall, .out_data
  );

`ifndef SYNTHESIS
  a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> out_data.last) else $error("queue popped before last result");
  a_event_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.packet_event != plsps_pkg::EV_NONE) |-> out_data.last)
    else $error("event on non-final result");
  a_tout_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.timed_out) |-> !out_data.byte_valid)
    else $error("timeout result carries a byte");
`endif
endmodule
